@@ rtl/bcsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bcsm_pkg
// Shared types and constants of the button chord sequence matcher: sizes,
// fire kinds, opcodes, the sequencer states and the transfer payloads.
// ----------------------------------------------------------------------------
package bcsm_pkg;

  // Sizes
  localparam int NUM_CMDS    = 32;
  localparam int MAX_STEPS   = 4;
  localparam int BUTTON_BITS = 16;

  localparam int CMD_W     = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1;
  localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int RAM_DEPTH = NUM_CMDS * MAX_STEPS;
  localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // Button positions with a special masking rule
  localparam int SELECT_BIT = 2;
  localparam int START_BIT  = 3;

  // Reset value of the gated command register
  localparam logic [4:0] GATED_RESET = 5'd20;

  // Item opcodes
  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Fire kinds (code 3 is stored but never fires)
  typedef enum logic [1:0] {
    KIND_HOLD  = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_ONCE  = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CUR,
    ST_PREV,
    ST_FILTER,
    ST_DONE
  } state_e;

  // Input item
  typedef struct packed {
    logic                   opcode;
    logic [BUTTON_BITS-1:0] held_buttons;
    logic [BUTTON_BITS-1:0] pressed_buttons;
    logic                   gate_open;
    logic                   only_first;
    logic [4:0]             command_slot;
    logic [1:0]             step_slot;
    logic [2:0]             sequence_length;
    logic                   exact_match;
    logic [1:0]             fire_kind;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [NUM_CMDS-1:0]    fired_mask;
    logic [BUTTON_BITS-1:0] filtered_held;
    logic [BUTTON_BITS-1:0] filtered_pressed;
  } out_item_t;

endpackage

@@ rtl/bcsm_ram.sv @@
// ----------------------------------------------------------------------------
// bcsm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/button_chord_sequence_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// button_chord_sequence_matcher_unit
// Matches programmed button chord sequences against controller frames and
// filters the buttons of completed chords out of the game inputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one item per
//   transfer: a frame sample or a write of one chord table entry. Output
//   channel (out_valid_o / out_stall_i / out_data_o) returns one result per
//   item. cfg_we_i / cfg_wdata_i write the gated command index (reset 20).
//   A write item goes straight to the final state, from which its result is
//   loaded into the output register. A frame scans the commands in index
//   order, stopping after the first unskipped one when only_first is set:
//   the single chord RAM read port and the one shared chord comparator visit
//   each command in turn, two reads per unskipped command.
//   in_stall_o is high while an item is in work; the next item is taken as
//   soon as the result sits in the output register, even if still stalled.
//   When the receiver stalls, the result holds and the sequencer waits in
//   its final state until the output register frees up.
//   Reset clears all command state and the ignore mask at once; the chord
//   RAM is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module button_chord_sequence_matcher_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bcsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bcsm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i
);

  import bcsm_pkg::*;

  // Relaxed or strict chord compare: the shared compare unit
  function automatic logic chord_hit(input logic [BUTTON_BITS-1:0] held,
                                     input logic [BUTTON_BITS-1:0] chord,
                                     input logic                   strict);
    logic res;
    if (strict) begin
      res = (held == chord);
    end else begin
      res = ((held & chord) == chord);
    end
    return res;
  endfunction

  // Sequencer and frame registers
  state_e                 state_q, state_d;
  logic [CMD_W-1:0]       idx_q, idx_d;
  logic [STEP_W-1:0]      p_q, p_d;
  logic [BUTTON_BITS-1:0] held_q, held_d;
  logic [BUTTON_BITS-1:0] pressed_q, pressed_d;
  logic                   gate_q, gate_d;
  logic                   first_q, first_d;
  logic [NUM_CMDS-1:0]    fired_q, fired_d;
  logic                   press_done_q, press_done_d;
  logic [BUTTON_BITS-1:0] ignore_q, ignore_d;
  logic                   hit_cur_q, hit_cur_d;
  logic [BUTTON_BITS-1:0] cur_chord_q, cur_chord_d;
  logic [BUTTON_BITS-1:0] filt_held_q, filt_held_d;
  logic [BUTTON_BITS-1:0] filt_pressed_q, filt_pressed_d;
  logic [4:0]             gated_q;

  // Per-command tables
  logic [LEN_W-1:0]  len_tab_q    [NUM_CMDS];
  logic              strict_tab_q [NUM_CMDS];
  logic [1:0]        kind_tab_q   [NUM_CMDS];
  logic [STEP_W-1:0] ptr_tab_q    [NUM_CMDS];
  logic              wait_tab_q   [NUM_CMDS];

  // Output register
  out_item_t out_q;
  logic      out_valid_q;

  // Control between sequencer and storage
  logic                   in_xfer, out_xfer, wr_xfer, slot_ok;
  logic                   ram_we;
  logic [RAM_AW-1:0]      ram_waddr, ram_raddr;
  logic [BUTTON_BITS-1:0] ram_rdata;
  logic                   tbl_upd, out_load;
  logic [STEP_W-1:0]      ptr_new;
  logic                   wait_new;
  logic [CMD_W-1:0]       wr_slot;
  logic [LEN_W-1:0]       wr_len;

  // Current command view
  logic [LEN_W-1:0]       cur_len;
  logic                   cur_strict;
  logic [1:0]             cur_kind;
  logic [STEP_W-1:0]      cur_ptr, p_eff, p_prev;
  logic                   cur_wait, skip, is_last, idx_last, cmp_hit;
  logic [BUTTON_BITS-1:0] prev_chord, new_ignore;

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign wr_xfer    = in_xfer && (in_data_i.opcode == OP_WRITE);
  assign slot_ok    = (32'(in_data_i.command_slot) < NUM_CMDS);
  assign wr_slot    = in_data_i.command_slot[CMD_W-1:0];
  assign wr_len     = (32'(in_data_i.sequence_length) > MAX_STEPS) ?
                      LEN_W'(MAX_STEPS) : LEN_W'(in_data_i.sequence_length);

  // Chord RAM write port
  assign ram_we    = wr_xfer && slot_ok && (32'(in_data_i.step_slot) < MAX_STEPS);
  assign ram_waddr = RAM_AW'(RAM_AW'(wr_slot) * RAM_AW'(MAX_STEPS))
                   + RAM_AW'(in_data_i.step_slot);

  bcsm_ram #(
    .WIDTH (BUTTON_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_chord_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.held_buttons),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Current command fields
  assign cur_len    = len_tab_q[idx_q];
  assign cur_strict = strict_tab_q[idx_q];
  assign cur_kind   = kind_tab_q[idx_q];
  assign cur_ptr    = ptr_tab_q[idx_q];
  assign cur_wait   = wait_tab_q[idx_q];
  assign skip       = (cur_len == '0) || ((32'(idx_q) == 32'(gated_q)) && !gate_q);
  assign p_eff      = (LEN_W'(cur_ptr) >= cur_len) ? '0 : cur_ptr;
  assign p_prev     = (p_q == '0) ? '0 : p_q - STEP_W'(1);
  assign is_last    = (LEN_W'(p_q) == cur_len - LEN_W'(1));
  assign idx_last   = (32'(idx_q) == NUM_CMDS - 1);
  assign cmp_hit    = chord_hit(held_q, ram_rdata, cur_strict);
  assign prev_chord = (p_q != '0) ? ram_rdata : '0;

  // Ignore mask grown by the buttons that the last chord of a completed sequence adds
  always_comb begin
    new_ignore = ignore_q | (cur_chord_q & ~prev_chord);
    if (new_ignore[SELECT_BIT]) begin
      new_ignore[START_BIT] = 1'b1;
    end
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    p_d            = p_q;
    held_d         = held_q;
    pressed_d      = pressed_q;
    gate_d         = gate_q;
    first_d        = first_q;
    fired_d        = fired_q;
    press_done_d   = press_done_q;
    ignore_d       = ignore_q;
    hit_cur_d      = hit_cur_q;
    cur_chord_d    = cur_chord_q;
    filt_held_d    = filt_held_q;
    filt_pressed_d = filt_pressed_q;
    ram_raddr      = RAM_AW'(RAM_AW'(idx_q) * RAM_AW'(MAX_STEPS)) + RAM_AW'(p_eff);
    tbl_upd        = 1'b0;
    ptr_new        = p_q;
    wait_new       = cur_wait;
    out_load       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          fired_d      = '0;
          press_done_d = 1'b0;
          if (in_data_i.opcode == OP_WRITE) begin
            filt_held_d    = '0;
            filt_pressed_d = '0;
            state_d        = ST_DONE;
          end else begin
            held_d       = in_data_i.held_buttons;
            pressed_d    = in_data_i.pressed_buttons;
            gate_d       = in_data_i.gate_open;
            first_d      = in_data_i.only_first;
            idx_d        = '0;
            state_d      = ST_ISSUE;
          end
        end
      end

      // read the chord at the step pointer, or pass a skipped command
      ST_ISSUE: begin
        if (skip) begin
          if (idx_last) begin
            state_d = ST_FILTER;
          end else begin
            idx_d = idx_q + CMD_W'(1);
          end
        end else begin
          p_d     = p_eff;
          state_d = ST_CUR;
        end
      end

      // compare the current chord, read the one before it
      ST_CUR: begin
        hit_cur_d   = cmp_hit;
        cur_chord_d = ram_rdata;
        ram_raddr   = RAM_AW'(RAM_AW'(idx_q) * RAM_AW'(MAX_STEPS)) + RAM_AW'(p_prev);
        state_d     = ST_PREV;
      end

      // step the command and decide whether it fires
      ST_PREV: begin
        tbl_upd = 1'b1;
        if (hit_cur_q) begin
          if (is_last) begin
            if (cur_kind == KIND_HOLD) begin
              fired_d = fired_q | (NUM_CMDS'(1) << idx_q);
            end else if (cur_kind == KIND_PRESS || cur_kind == KIND_ONCE) begin
              if (cur_kind == KIND_ONCE) begin
                ptr_new = '0;
              end
              if (!cur_wait && !press_done_q) begin
                fired_d      = fired_q | (NUM_CMDS'(1) << idx_q);
                wait_new     = 1'b1;
                press_done_d = 1'b1;
              end
            end
            ignore_d = new_ignore;
          end else begin
            ptr_new = p_q + STEP_W'(1);
          end
        end else if ((p_q != '0) && cmp_hit) begin
          wait_new = 1'b0;
        end else begin
          ptr_new  = '0;
          wait_new = 1'b0;
        end
        if (first_q || idx_last) begin
          state_d = ST_FILTER;
        end else begin
          idx_d   = idx_q + CMD_W'(1);
          state_d = ST_ISSUE;
        end
      end

      // clear masked buttons, drop the mask once all its buttons are released
      ST_FILTER: begin
        filt_held_d    = held_q;
        filt_pressed_d = pressed_q;
        if (ignore_q != '0) begin
          if ((held_q & ignore_q) != '0) begin
            filt_held_d    = held_q & ~ignore_q;
            filt_pressed_d = pressed_q & ~ignore_q;
          end else begin
            ignore_d = '0;
          end
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      press_done_q <= 1'b0;
      ignore_q     <= '0;
      gated_q      <= GATED_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      press_done_q <= press_done_d;
      ignore_q     <= ignore_d;
      if (cfg_we_i) begin
        gated_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_q            <= p_d;
    held_q         <= held_d;
    pressed_q      <= pressed_d;
    gate_q         <= gate_d;
    first_q        <= first_d;
    fired_q        <= fired_d;
    hit_cur_q      <= hit_cur_d;
    cur_chord_q    <= cur_chord_d;
    filt_held_q    <= filt_held_d;
    filt_pressed_q <= filt_pressed_d;
    if (out_load) begin
      out_q.fired_mask       <= fired_q;
      out_q.filtered_held    <= filt_held_q;
      out_q.filtered_pressed <= filt_pressed_q;
    end
  end

  // Command tables: programmed by write items, stepped by the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CMDS; i++) begin
        len_tab_q[i]    <= '0;
        strict_tab_q[i] <= 1'b0;
        kind_tab_q[i]   <= '0;
        ptr_tab_q[i]    <= '0;
        wait_tab_q[i]   <= 1'b0;
      end
    end else if (wr_xfer && slot_ok) begin
      len_tab_q[wr_slot]    <= wr_len;
      strict_tab_q[wr_slot] <= in_data_i.exact_match;
      kind_tab_q[wr_slot]   <= in_data_i.fire_kind;
      ptr_tab_q[wr_slot]    <= '0;
      wait_tab_q[wr_slot]   <= 1'b0;
    end else if (tbl_upd) begin
      ptr_tab_q[idx_q]  <= ptr_new;
      wait_tab_q[idx_q] <= wait_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a frame transfer starts the scan at command zero
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.opcode == OP_FRAME) |=> (state_q == ST_ISSUE && idx_q == '0))
    else $error("frame transfer did not start the scan");

  // a write transfer goes straight to the result stage
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_xfer |=> (state_q == ST_DONE))
    else $error("write transfer did not go to result stage");

  // a result only appears from the result stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside result stage");

  // a press fired this frame leaves a bit in the fired mask
  a_press_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (press_done_q && state_q != ST_IDLE) |-> (fired_q != '0))
    else $error("press marked done without a fired command");
`endif

endmodule

@@ sim/chord_match_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chord_match_checker
// Watches the item, result and register ports of the chord sequence matcher.
// It keeps its own copy of the command tables and the ignore mask, works out
// the result of every item taken in, and compares the results that come out
// in order, field by field.
// ----------------------------------------------------------------------------
module chord_match_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  bcsm_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bcsm_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  import bcsm_pkg::*;

  // Shadow of the matcher state
  logic [BUTTON_BITS-1:0] chord_mem [RAM_DEPTH];
  logic [LEN_W-1:0]       len_tab   [NUM_CMDS];
  logic                   exact_tab [NUM_CMDS];
  logic [1:0]             kind_tab  [NUM_CMDS];
  logic [STEP_W-1:0]      ptr_tab   [NUM_CMDS];
  logic                   armed_tab [NUM_CMDS];
  logic [BUTTON_BITS-1:0] ignore_q;
  logic [4:0]             gated_q;

  out_item_t expected_results [$];
  out_item_t exp_item;

  function automatic logic chord_hit(logic [BUTTON_BITS-1:0] held,
                                     logic [BUTTON_BITS-1:0] chord, logic exact);
    if (exact) return held == chord;
    return (held & chord) == chord;
  endfunction

  // Applies one item to the shadow state and returns the result it causes
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t              res;
    logic [BUTTON_BITS-1:0] held, pressed, prev_chord, added;
    logic [NUM_CMDS-1:0]    fired;
    logic                   press_done, scan_on;
    int                     len, p, base, slot;
    res = '0;
    if (it.opcode == OP_WRITE) begin
      slot = it.command_slot;
      len  = (it.sequence_length > MAX_STEPS) ? MAX_STEPS : it.sequence_length;
      chord_mem[slot * MAX_STEPS + it.step_slot] = it.held_buttons;
      len_tab[slot]   = len[LEN_W-1:0];
      exact_tab[slot] = it.exact_match;
      kind_tab[slot]  = it.fire_kind;
      ptr_tab[slot]   = '0;
      armed_tab[slot] = 1'b0;
      return res;
    end

    held       = it.held_buttons;
    pressed    = it.pressed_buttons;
    fired      = '0;
    press_done = 1'b0;
    scan_on    = 1'b1;
    // Scan the commands in index order
    for (int i = 0; i < NUM_CMDS; i++) begin
      len = len_tab[i];
      if (scan_on && len != 0 && !(i == gated_q && !it.gate_open)) begin
        p    = ptr_tab[i];
        base = i * MAX_STEPS;
        if (p >= len) p = 0;
        if (chord_hit(held, chord_mem[base + p], exact_tab[i])) begin
          if (p == len - 1) begin
            prev_chord = (len > 1) ? chord_mem[base + len - 2] : '0;
            if (kind_tab[i] == KIND_HOLD) begin
              fired[i] = 1'b1;
            end else if (kind_tab[i] == KIND_PRESS || kind_tab[i] == KIND_ONCE) begin
              if (kind_tab[i] == KIND_ONCE) p = 0;
              if (!armed_tab[i] && !press_done) begin
                fired[i]     = 1'b1;
                armed_tab[i] = 1'b1;
                press_done   = 1'b1;
              end
            end
            // mask the buttons that the last chord adds
            added    = chord_mem[base + len - 1] & ~prev_chord;
            ignore_q = ignore_q | added;
            if (ignore_q[SELECT_BIT]) ignore_q[START_BIT] = 1'b1;
          end else begin
            p++;
          end
        end else if (p > 0 && chord_hit(held, chord_mem[base + p - 1], exact_tab[i])) begin
          armed_tab[i] = 1'b0;
        end else begin
          p            = 0;
          armed_tab[i] = 1'b0;
        end
        ptr_tab[i] = p[STEP_W-1:0];
        if (it.only_first) scan_on = 1'b0;
      end
    end

    // Filter the game buttons; mask drops once none of it is held
    if (ignore_q != '0) begin
      if ((held & ignore_q) != '0) begin
        held    = held & ~ignore_q;
        pressed = pressed & ~ignore_q;
      end else begin
        ignore_q = '0;
      end
    end

    res.fired_mask       = fired;
    res.filtered_held    = held;
    res.filtered_pressed = pressed;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Track transfers on every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RAM_DEPTH; i++) chord_mem[i] = '0;
      for (int i = 0; i < NUM_CMDS; i++) begin
        len_tab[i]   = '0;
        exact_tab[i] = 1'b0;
        kind_tab[i]  = '0;
        ptr_tab[i]   = '0;
        armed_tab[i] = 1'b0;
      end
      ignore_q = '0;
      gated_q  = GATED_RESET;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) gated_q = cfg_wdata_i;

      // result transfer: compare with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
        end else begin
          exp_item = expected_results.pop_front();
          check_field("fired_mask", exp_item.fired_mask, out_data_i.fired_mask);
          check_field("filtered_held", exp_item.filtered_held, out_data_i.filtered_held);
          check_field("filtered_pressed", exp_item.filtered_pressed,
                      out_data_i.filtered_pressed);
        end
      end

      // item transfer: predict its result
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_result(in_data_i));

      pending_o = expected_results.size();
    end
  end

endmodule

@@ sim/tb_button_chord_sequence_matcher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_chord_sequence_matcher_unit
// Drives the chord sequence matcher with table writes and controller frames:
// a directed opening, then programmed combos walked step by step mixed with
// random frames and writes, under three idling patterns and several gated
// command settings. The checker beside the block reports the failures.
// ----------------------------------------------------------------------------
module tb_button_chord_sequence_matcher_unit;
  import bcsm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  int         fail_count;
  int         pending;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int cycle_count;

  // What has been programmed, so frames can follow the combos
  logic [BUTTON_BITS-1:0] chord_sh   [RAM_DEPTH];
  bit                     written_sh [RAM_DEPTH];
  int                     len_sh     [NUM_CMDS];
  bit                     exact_sh   [NUM_CMDS];

  button_chord_sequence_matcher_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  chord_match_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // One item transfer; returns at the falling edge after it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [BUTTON_BITS-1:0] sparse_buttons();
    logic [BUTTON_BITS-1:0] v;
    v = '0;
    repeat ($urandom_range(1, 3)) v[$urandom_range(BUTTON_BITS - 1)] = 1'b1;
    if ($urandom_range(15) == 0) v = BUTTON_BITS'($urandom);
    if ($urandom_range(31) == 0) v = '0;
    return v;
  endfunction

  // Table write; the length is cut back so no unwritten chord is ever read
  task automatic write_entry(int c, int s, logic [BUTTON_BITS-1:0] chord, int len_field,
                             bit exact, int kind);
    in_item_t    it;
    logic [63:0] noise;
    int          ready, eff;
    written_sh[c * MAX_STEPS + s] = 1'b1;
    chord_sh[c * MAX_STEPS + s]   = chord;
    ready = 0;
    while (ready < MAX_STEPS && written_sh[c * MAX_STEPS + ready]) ready++;
    eff = (len_field > MAX_STEPS) ? MAX_STEPS : len_field;
    if (eff > ready) begin
      len_field = ready;
      eff       = ready;
    end
    len_sh[c]   = eff;
    exact_sh[c] = exact;
    noise = {$urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.opcode          = OP_WRITE;
    it.held_buttons    = chord;
    it.command_slot    = c[4:0];
    it.step_slot       = s[1:0];
    it.sequence_length = len_field[2:0];
    it.exact_match     = exact;
    it.fire_kind       = kind[1:0];
    send_item(it);
  endtask

  task automatic send_frame(logic [BUTTON_BITS-1:0] held, logic [BUTTON_BITS-1:0] pressed,
                            bit gate, bit first);
    in_item_t    it;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.opcode          = OP_FRAME;
    it.held_buttons    = held;
    it.pressed_buttons = pressed;
    it.gate_open       = gate;
    it.only_first      = first;
    send_item(it);
  endtask

  task automatic random_frame(logic [BUTTON_BITS-1:0] held);
    logic [BUTTON_BITS-1:0] pressed;
    pressed = ($urandom_range(3) == 0) ? BUTTON_BITS'($urandom)
                                       : (held & BUTTON_BITS'($urandom));
    send_frame(held, pressed, $urandom_range(9) != 0, $urandom_range(9) == 0);
  endtask

  // Program a whole combo; each step write grows the length by one
  task automatic program_random_cmd();
    logic [BUTTON_BITS-1:0] chord;
    int c, steps, kind, len_field;
    bit exact;
    c     = $urandom_range(NUM_CMDS - 1);
    steps = $urandom_range(1, MAX_STEPS);
    exact = 1'($urandom_range(1));
    kind  = $urandom_range(3);
    chord = sparse_buttons();
    for (int s = 0; s < steps; s++) begin
      if (s > 0) begin
        if ($urandom_range(3) != 0) chord[$urandom_range(BUTTON_BITS - 1)] = 1'b1;
        else chord = sparse_buttons();
      end
      len_field = (s == MAX_STEPS - 1) ? $urandom_range(MAX_STEPS, 7) : s + 1;
      write_entry(c, s, chord, len_field, exact, kind);
    end
  endtask

  // Walk a programmed combo, holding each chord for a few frames
  task automatic walk_cmd(int c);
    logic [BUTTON_BITS-1:0] held;
    int steps;
    steps = len_sh[c];
    for (int k = 0; k < steps; k++) begin
      repeat ($urandom_range(1, (k == steps - 1) ? 3 : 2)) begin
        held = chord_sh[c * MAX_STEPS + k];
        if (!exact_sh[c] && $urandom_range(1)) held = held | sparse_buttons();
        if ($urandom_range(9) == 0) held = sparse_buttons();
        random_frame(held);
      end
    end
    repeat ($urandom_range(0, 2)) random_frame($urandom_range(1) ? '0 : sparse_buttons());
  endtask

  task automatic random_part(int target);
    int enabled [$];
    int pick;
    while (items_sent < target) begin
      enabled.delete();
      for (int c = 0; c < NUM_CMDS; c++) if (len_sh[c] > 0) enabled.push_back(c);
      pick = $urandom_range(99);
      if (pick < 12 || enabled.size() == 0) begin
        program_random_cmd();
      end else if (pick < 17) begin
        write_entry($urandom_range(NUM_CMDS - 1), $urandom_range(MAX_STEPS - 1),
                    $urandom_range(1) ? sparse_buttons() : BUTTON_BITS'($urandom),
                    $urandom_range(7), 1'($urandom_range(1)), $urandom_range(3));
      end else if (pick < 30) begin
        random_frame($urandom_range(1) ? BUTTON_BITS'($urandom) : sparse_buttons());
      end else begin
        walk_cmd(enabled[$urandom_range(enabled.size() - 1)]);
      end
    end
  endtask

  // Lower valid and wait for every result to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_gated(logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    items_sent  = 0;
    cycle_count = 0;
    send_idle_pct  = 26;
    recv_stall_pct = 70;
    for (int i = 0; i < RAM_DEPTH; i++) begin
      chord_sh[i]   = '0;
      written_sh[i] = 1'b0;
    end
    for (int i = 0; i < NUM_CMDS; i++) begin
      len_sh[i]   = 0;
      exact_sh[i] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: nothing programmed, all buttons pass through
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    // strict press on Select, masking Select also masks Start
    write_entry(0, 0, 16'h0004, 1, 1'b1, KIND_PRESS);
    send_frame(16'h0004, 16'h0004, 1'b1, 1'b0);
    send_frame(16'h000C, 16'h0008, 1'b1, 1'b0);
    send_frame(16'h0004, 16'hFFFF, 1'b1, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b0);
    // relaxed three-step press-once combo
    write_entry(1, 0, 16'h0010, 1, 1'b0, KIND_ONCE);
    write_entry(1, 1, 16'h0030, 2, 1'b0, KIND_ONCE);
    write_entry(1, 2, 16'h0070, 3, 1'b0, KIND_ONCE);
    send_frame(16'h0010, 16'h0010, 1'b1, 1'b0);
    send_frame(16'h0030, 16'h0020, 1'b1, 1'b0);
    send_frame(16'h00F0, 16'h00C0, 1'b1, 1'b0);
    send_frame(16'h00F0, 16'h0000, 1'b1, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b0);
    // four-step strict combo of the unused kind, length field saturates
    write_entry(2, 0, 16'h8000, 1, 1'b1, 3);
    write_entry(2, 1, 16'hC000, 2, 1'b1, 3);
    write_entry(2, 2, 16'hE000, 3, 1'b1, 3);
    write_entry(2, 3, 16'hF000, 7, 1'b1, 3);
    send_frame(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_frame(16'hC000, 16'h4000, 1'b1, 1'b0);
    send_frame(16'hE000, 16'h2000, 1'b1, 1'b0);
    send_frame(16'hF000, 16'h1000, 1'b1, 1'b0);
    // hold command on the gated index, gate shut then open
    write_entry(20, 0, 16'h0001, 1, 1'b0, KIND_HOLD);
    send_frame(16'h0001, 16'h0001, 1'b0, 1'b0);
    send_frame(16'h0001, 16'h0000, 1'b1, 1'b0);
    // only the first enabled command is scanned
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b0);

    // Random: sender idles lightly, receiver stalls heavily
    wait_drained();
    write_gated(5'd0);
    random_part(items_sent + PHASE_ITEMS);

    // Random: the other way round
    wait_drained();
    send_idle_pct  = 70;
    recv_stall_pct = 26;
    write_gated(5'd31);
    random_part(items_sent + PHASE_ITEMS);

    // Random: no idling at all
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_gated(5'($urandom_range(1, 30)));
    random_part(items_sent + PHASE_ITEMS);

    wait_drained();
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bcsm_pkg.sv
rtl/bcsm_ram.sv
rtl/button_chord_sequence_matcher_unit.sv
sim/chord_match_checker.sv
sim/tb_button_chord_sequence_matcher_unit.sv
